FILE: sv/rhc_pkg.sv
// Shared types and constants for the RGB/HSV color converter.
package rhc_pkg;

    localparam int CH_W        = 12;
    localparam int SEXT_SPAN   = 682;
    localparam int HUE_GREEN   = 1365;
    localparam int HUE_BLUE    = 2730;
    localparam int FULL_CIRCLE = 4092;
    localparam int CH_MAX      = 4095;

    // Saturation divider yields 13 quotient bits, hue divider 10 (quotient <= 682).
    localparam int SAT_STEPS   = 13;
    localparam int HUE_STEPS   = 10;
    localparam int HUE_SKIP    = SAT_STEPS - HUE_STEPS;
    localparam int PROD_W      = CH_W + HUE_STEPS;

    // Register stages from the input to the result register, per path.
    localparam int PATH_STAGES = 2 + SAT_STEPS;
    localparam int HSV_CORE    = 5;
    localparam int HSV_PAD     = PATH_STAGES - HSV_CORE;
    localparam int LATENCY     = PATH_STAGES + 1;

    localparam logic REQ_RGB2HSV = 1'b0;
    localparam logic REQ_HSV2RGB = 1'b1;

    typedef logic [CH_W-1:0] chan_t;

    typedef enum logic [2:0] {
        SEL_RED   = 3'b001,
        SEL_GREEN = 3'b010,
        SEL_BLUE  = 3'b100
    } hue_sel_t;

    typedef struct packed {
        hue_sel_t sel;
        logic     neg;
        logic     grey;
        logic     black;
    } hue_ctl_t;

endpackage

FILE: sv/rhc_rgb_front.sv
// RGB front end: max/min, channel difference and hue numerator product.
module rhc_rgb_front
    import rhc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  chan_t            red,
    input  chan_t            green,
    input  chan_t            blue,
    output logic             out_valid,
    output chan_t            out_max,
    output chan_t            out_delta,
    output logic [PROD_W-1:0] out_prod,
    output hue_ctl_t         out_ctl
);

    chan_t    mx_next;
    chan_t    mn_next;
    chan_t    abs_next;
    hue_ctl_t ctl_next;
    chan_t    num_a;
    chan_t    num_b;

    logic     v1_reg;
    chan_t    mx1_reg;
    chan_t    d1_reg;
    chan_t    abs1_reg;
    hue_ctl_t ctl1_reg;

    logic              v2_reg;
    chan_t             mx2_reg;
    chan_t             d2_reg;
    logic [PROD_W-1:0] prod2_reg;
    hue_ctl_t          ctl2_reg;

    always_comb
    begin
        mx_next = red;
        mn_next = red;
        if (green > mx_next)
        begin
            mx_next = green;
        end
        if (blue > mx_next)
        begin
            mx_next = blue;
        end
        if (green < mn_next)
        begin
            mn_next = green;
        end
        if (blue < mn_next)
        begin
            mn_next = blue;
        end

        // Ties go red over green over blue.
        if (mx_next == red)
        begin
            ctl_next.sel = SEL_RED;
            num_a        = green;
            num_b        = blue;
        end
        else if (mx_next == green)
        begin
            ctl_next.sel = SEL_GREEN;
            num_a        = blue;
            num_b        = red;
        end
        else
        begin
            ctl_next.sel = SEL_BLUE;
            num_a        = red;
            num_b        = green;
        end
        ctl_next.neg   = (num_a < num_b);
        ctl_next.grey  = (mx_next == mn_next);
        ctl_next.black = (mx_next == '0);
        abs_next       = ctl_next.neg ? (num_b - num_a) : (num_a - num_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mx1_reg   <= mx_next;
        d1_reg    <= mx_next - mn_next;
        abs1_reg  <= abs_next;
        ctl1_reg  <= ctl_next;
        mx2_reg   <= mx1_reg;
        d2_reg    <= d1_reg;
        prod2_reg <= PROD_W'(abs1_reg) * PROD_W'(SEXT_SPAN);
        ctl2_reg  <= ctl1_reg;
    end

    assign out_valid = v2_reg;
    assign out_max   = mx2_reg;
    assign out_delta = d2_reg;
    assign out_prod  = prod2_reg;
    assign out_ctl   = ctl2_reg;

endmodule

FILE: sv/rhc_div_pipe.sv
// Pipelined restoring dividers: one saturation quotient bit per stage, hue bits in the later stages.
module rhc_div_pipe
    import rhc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  chan_t             in_max,
    input  chan_t             in_delta,
    input  logic [PROD_W-1:0] in_prod,
    input  hue_ctl_t          in_ctl,
    output logic              out_valid,
    output chan_t             hue,
    output chan_t             sat,
    output chan_t             value
);

    logic                  vld_reg  [1:SAT_STEPS];
    chan_t                 mx_reg   [1:SAT_STEPS];
    logic [SAT_STEPS-1:0]  squo_reg [1:SAT_STEPS];
    logic [HUE_STEPS-1:0]  hquo_reg [1:SAT_STEPS];
    hue_ctl_t              ctl_reg  [1:SAT_STEPS];
    chan_t                 d_reg    [1:SAT_STEPS-1];
    chan_t                 srem_reg [1:SAT_STEPS-1];
    chan_t                 hrem_reg [1:SAT_STEPS-1];
    logic [HUE_STEPS-1:0]  plo_reg  [1:SAT_STEPS-1];

    chan_t                 q_ext;
    hue_ctl_t              ctl_out;

    for (genvar i = 0; i < SAT_STEPS; i++)
    begin : g_step
        logic                 vld_in;
        chan_t                mx_in;
        chan_t                d_in;
        chan_t                srem_in;
        chan_t                hrem_in;
        logic [SAT_STEPS-1:0] squo_in;
        logic [HUE_STEPS-1:0] hquo_in;
        logic [HUE_STEPS-1:0] plo_in;
        hue_ctl_t             ctl_in;
        logic [CH_W:0]        s_trial;
        logic [CH_W:0]        s_diff;
        logic                 s_ge;
        chan_t                srem_next;
        chan_t                hrem_next;
        logic [HUE_STEPS-1:0] hquo_next;

        if (i == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign mx_in   = in_max;
            assign d_in    = in_delta;
            assign srem_in = in_delta;
            assign hrem_in = in_prod[PROD_W-1:HUE_STEPS];
            assign plo_in  = in_prod[HUE_STEPS-1:0];
            assign squo_in = '0;
            assign hquo_in = '0;
            assign ctl_in  = in_ctl;
            // First saturation bit compares delta itself (quotient may reach 4096).
            assign s_trial = {1'b0, srem_in};
        end
        else
        begin : g_later
            assign vld_in  = vld_reg[i];
            assign mx_in   = mx_reg[i];
            assign d_in    = d_reg[i];
            assign srem_in = srem_reg[i];
            assign hrem_in = hrem_reg[i];
            assign plo_in  = plo_reg[i];
            assign squo_in = squo_reg[i];
            assign hquo_in = hquo_reg[i];
            assign ctl_in  = ctl_reg[i];
            assign s_trial = {srem_in, 1'b0};
        end

        assign s_diff    = s_trial - {1'b0, mx_in};
        assign s_ge      = (s_trial >= {1'b0, mx_in});
        assign srem_next = s_ge ? s_diff[CH_W-1:0] : s_trial[CH_W-1:0];

        if (i >= HUE_SKIP)
        begin : g_hue
            logic [CH_W:0] h_trial;
            logic [CH_W:0] h_diff;
            logic          h_ge;

            assign h_trial   = {hrem_in, plo_in[HUE_STEPS-1-(i-HUE_SKIP)]};
            assign h_diff    = h_trial - {1'b0, d_in};
            assign h_ge      = (h_trial >= {1'b0, d_in});
            assign hrem_next = h_ge ? h_diff[CH_W-1:0] : h_trial[CH_W-1:0];
            assign hquo_next = {hquo_in[HUE_STEPS-2:0], h_ge};
        end
        else
        begin : g_hold
            assign hrem_next = hrem_in;
            assign hquo_next = hquo_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            mx_reg[i+1]   <= mx_in;
            squo_reg[i+1] <= {squo_in[SAT_STEPS-2:0], s_ge};
            hquo_reg[i+1] <= hquo_next;
            ctl_reg[i+1]  <= ctl_in;
        end

        if (i < SAT_STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                d_reg[i+1]    <= d_in;
                srem_reg[i+1] <= srem_next;
                hrem_reg[i+1] <= hrem_next;
                plo_reg[i+1]  <= plo_in;
            end
        end
    end

    assign ctl_out = ctl_reg[SAT_STEPS];
    assign q_ext   = CH_W'(hquo_reg[SAT_STEPS]);

    always_comb
    begin
        hue = '0;
        if (!ctl_out.grey && !ctl_out.black)
        begin
            case (ctl_out.sel)
                SEL_RED:
                begin
                    // Wrap a negative red hue back into the top sextant.
                    if (ctl_out.neg && (q_ext != '0))
                    begin
                        hue = CH_W'(FULL_CIRCLE) - q_ext;
                    end
                    else
                    begin
                        hue = q_ext;
                    end
                end
                SEL_GREEN:
                begin
                    hue = ctl_out.neg ? (CH_W'(HUE_GREEN) - q_ext) : (CH_W'(HUE_GREEN) + q_ext);
                end
                default:
                begin
                    hue = ctl_out.neg ? (CH_W'(HUE_BLUE) - q_ext) : (CH_W'(HUE_BLUE) + q_ext);
                end
            endcase
        end
    end

    always_comb
    begin
        if (ctl_out.black)
        begin
            sat = '0;
        end
        else if (squo_reg[SAT_STEPS][SAT_STEPS-1])
        begin
            sat = CH_W'(CH_MAX);
        end
        else
        begin
            sat = squo_reg[SAT_STEPS][CH_W-1:0];
        end
    end

    assign value     = mx_reg[SAT_STEPS];
    assign out_valid = vld_reg[SAT_STEPS];

endmodule

FILE: sv/rhc_hsv_path.sv
// HSV to RGB path: sextant split, p/q/t products, channel mapping, alignment delay.
module rhc_hsv_path
    import rhc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  chan_t hue,
    input  chan_t sat,
    input  chan_t value,
    output logic  out_valid,
    output chan_t red,
    output chan_t green,
    output chan_t blue
);

    localparam int MUL_W = 2 * CH_W;

    logic [2:0] sext_next;
    chan_t      base_next;
    logic [9:0] frac_next;

    logic       v1_reg;
    logic [2:0] sext1_reg;
    chan_t      rem1_reg;
    chan_t      s1_reg;
    chan_t      val1_reg;

    logic             v2_reg;
    logic [2:0]       sext2_reg;
    chan_t            val2_reg;
    logic [MUL_W-1:0] m1_reg;
    logic [MUL_W-1:0] m2_reg;
    logic [MUL_W-1:0] mp_reg;

    logic       v3_reg;
    logic [2:0] sext3_reg;
    chan_t      val3_reg;
    chan_t      qi3_reg;
    chan_t      ti3_reg;
    chan_t      p3_reg;

    logic             v4_reg;
    logic [2:0]       sext4_reg;
    chan_t            val4_reg;
    chan_t            p4_reg;
    logic [MUL_W-1:0] mq4_reg;
    logic [MUL_W-1:0] mt4_reg;

    chan_t q4;
    chan_t t4;
    chan_t r_next;
    chan_t g_next;
    chan_t b_next;

    logic  v5_reg;
    chan_t r5_reg;
    chan_t g5_reg;
    chan_t b5_reg;

    logic  pv_reg [0:HSV_PAD-1];
    chan_t pr_reg [0:HSV_PAD-1];
    chan_t pg_reg [0:HSV_PAD-1];
    chan_t pb_reg [0:HSV_PAD-1];

    always_comb
    begin
        sext_next = '0;
        for (int k = 1; k <= 6; k++)
        begin
            if (hue >= CH_W'(k * SEXT_SPAN))
            begin
                sext_next = 3'(k);
            end
        end
        base_next = CH_W'(32'(sext_next) * SEXT_SPAN);
        frac_next = 10'(hue - base_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sext1_reg <= sext_next;
        rem1_reg  <= (CH_W'(frac_next) << 2) + (CH_W'(frac_next) << 1);
        s1_reg    <= sat;
        val1_reg  <= value;

        sext2_reg <= sext1_reg;
        val2_reg  <= val1_reg;
        m1_reg    <= MUL_W'(s1_reg) * MUL_W'(rem1_reg);
        m2_reg    <= MUL_W'(s1_reg) * MUL_W'(CH_W'(CH_MAX) - rem1_reg);
        mp_reg    <= MUL_W'(val1_reg) * MUL_W'(CH_W'(CH_MAX) - s1_reg);

        sext3_reg <= sext2_reg;
        val3_reg  <= val2_reg;
        qi3_reg   <= CH_W'(CH_MAX) - m1_reg[MUL_W-1:CH_W];
        ti3_reg   <= CH_W'(CH_MAX) - m2_reg[MUL_W-1:CH_W];
        p3_reg    <= mp_reg[MUL_W-1:CH_W];

        sext4_reg <= sext3_reg;
        val4_reg  <= val3_reg;
        p4_reg    <= p3_reg;
        mq4_reg   <= MUL_W'(val3_reg) * MUL_W'(qi3_reg);
        mt4_reg   <= MUL_W'(val3_reg) * MUL_W'(ti3_reg);

        r5_reg    <= r_next;
        g5_reg    <= g_next;
        b5_reg    <= b_next;
    end

    assign q4 = mq4_reg[MUL_W-1:CH_W];
    assign t4 = mt4_reg[MUL_W-1:CH_W];

    // The top partial sextant (hue 4092 and up) maps like sextant five.
    always_comb
    begin
        case (sext4_reg)
            3'd0:
            begin
                r_next = val4_reg; g_next = t4;       b_next = p4_reg;
            end
            3'd1:
            begin
                r_next = q4;       g_next = val4_reg; b_next = p4_reg;
            end
            3'd2:
            begin
                r_next = p4_reg;   g_next = val4_reg; b_next = t4;
            end
            3'd3:
            begin
                r_next = p4_reg;   g_next = q4;       b_next = val4_reg;
            end
            3'd4:
            begin
                r_next = t4;       g_next = p4_reg;   b_next = val4_reg;
            end
            default:
            begin
                r_next = val4_reg; g_next = p4_reg;   b_next = q4;
            end
        endcase
    end

    // Delay to match the divider path so results leave in order.
    for (genvar i = 0; i < HSV_PAD; i++)
    begin : g_pad
        logic  v_in;
        chan_t r_in;
        chan_t g_in;
        chan_t b_in;

        if (i == 0)
        begin : g_head
            assign v_in = v5_reg;
            assign r_in = r5_reg;
            assign g_in = g5_reg;
            assign b_in = b5_reg;
        end
        else
        begin : g_tail
            assign v_in = pv_reg[i-1];
            assign r_in = pr_reg[i-1];
            assign g_in = pg_reg[i-1];
            assign b_in = pb_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pv_reg[i] <= 1'b0;
            end
            else
            begin
                pv_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            pr_reg[i] <= r_in;
            pg_reg[i] <= g_in;
            pb_reg[i] <= b_in;
        end
    end

    assign out_valid = pv_reg[HSV_PAD-1];
    assign red       = pr_reg[HSV_PAD-1];
    assign green     = pg_reg[HSV_PAD-1];
    assign blue      = pb_reg[HSV_PAD-1];

endmodule

FILE: sv/rgb_hsv_color_converter.sv
// Top level of the RGB/HSV color converter: both paths and the result register.
//
//  channel   | handshake          | fields
//  ----------+--------------------+----------------------------------------------
//  request   | start / busy       | req_type, red_or_hue, green_or_sat, blue_or_value
//  result    | done (one cycle)   | hue_or_red, sat_or_green, value_or_blue
//
// An item is taken in every cycle; busy stays low.
// Results leave in order. Each item passes the two front-end stages, the 13 one-bit
// saturation divider stages and the output register on its way to the outputs.
// The HSV to RGB path is padded to the same depth.
// Reset clears only the valid bits; no result is lost since the receiver never stalls.
module rgb_hsv_color_converter
    import rhc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  logic  req_type,
    input  chan_t red_or_hue,
    input  chan_t green_or_sat,
    input  chan_t blue_or_value,
    output logic  done,
    output chan_t hue_or_red,
    output chan_t sat_or_green,
    output chan_t value_or_blue
);

    logic              accept;
    logic              rgb_in_valid;
    logic              hsv_in_valid;

    logic              front_valid;
    chan_t             front_max;
    chan_t             front_delta;
    logic [PROD_W-1:0] front_prod;
    hue_ctl_t          front_ctl;

    logic              div_valid;
    chan_t             div_hue;
    chan_t             div_sat;
    chan_t             div_value;

    logic              hsv_valid;
    chan_t             hsv_red;
    chan_t             hsv_green;
    chan_t             hsv_blue;

    logic              done_reg;
    chan_t             a_reg;
    chan_t             b_reg;
    chan_t             c_reg;

    assign busy         = 1'b0;
    assign accept       = start && !busy;
    assign rgb_in_valid = accept && (req_type == REQ_RGB2HSV);
    assign hsv_in_valid = accept && (req_type == REQ_HSV2RGB);

    rhc_rgb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rgb_in_valid),
        .red       (red_or_hue),
        .green     (green_or_sat),
        .blue      (blue_or_value),
        .out_valid (front_valid),
        .out_max   (front_max),
        .out_delta (front_delta),
        .out_prod  (front_prod),
        .out_ctl   (front_ctl)
    );

    rhc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_max    (front_max),
        .in_delta  (front_delta),
        .in_prod   (front_prod),
        .in_ctl    (front_ctl),
        .out_valid (div_valid),
        .hue       (div_hue),
        .sat       (div_sat),
        .value     (div_value)
    );

    rhc_hsv_path u_hsv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hsv_in_valid),
        .hue       (red_or_hue),
        .sat       (green_or_sat),
        .value     (blue_or_value),
        .out_valid (hsv_valid),
        .red       (hsv_red),
        .green     (hsv_green),
        .blue      (hsv_blue)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid || hsv_valid;
        end
    end

    // Both paths have equal depth, so at most one presents an item per cycle.
    always_ff @(posedge clk)
    begin
        if (div_valid)
        begin
            a_reg <= div_hue;
            b_reg <= div_sat;
            c_reg <= div_value;
        end
        else
        begin
            a_reg <= hsv_red;
            b_reg <= hsv_green;
            c_reg <= hsv_blue;
        end
    end

    assign done          = done_reg;
    assign hue_or_red    = a_reg;
    assign sat_or_green  = b_reg;
    assign value_or_blue = c_reg;

endmodule

FILE: sv/rhc_checker.sv
// Port-level checks for the color converter, bound to the top level.
module rhc_checker
    import rhc_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  start,
    input logic  busy,
    input logic  req_type,
    input chan_t red_or_hue,
    input chan_t green_or_sat,
    input chan_t blue_or_value,
    input logic  done,
    input chan_t hue_or_red,
    input chan_t sat_or_green,
    input chan_t value_or_blue
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without an item taken");

    a_value_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(req_type == REQ_RGB2HSV, LATENCY) |->
            value_or_blue >= $past(red_or_hue, LATENCY) &&
            value_or_blue >= $past(green_or_sat, LATENCY) &&
            value_or_blue >= $past(blue_or_value, LATENCY) &&
            (value_or_blue == $past(red_or_hue, LATENCY) ||
             value_or_blue == $past(green_or_sat, LATENCY) ||
             value_or_blue == $past(blue_or_value, LATENCY)))
        else $error("value is not the largest channel");

    a_black_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(req_type == REQ_RGB2HSV && red_or_hue == '0 &&
                      green_or_sat == '0 && blue_or_value == '0, LATENCY) |->
            hue_or_red == '0 && sat_or_green == '0 && value_or_blue == '0)
        else $error("black item gave nonzero HSV");

endmodule

bind rgb_hsv_color_converter rhc_checker u_rhc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .red_or_hue    (red_or_hue),
    .green_or_sat  (green_or_sat),
    .blue_or_value (blue_or_value),
    .done          (done),
    .hue_or_red    (hue_or_red),
    .sat_or_green  (sat_or_green),
    .value_or_blue (value_or_blue)
);
